// File: design/h264dp_pkg.sv
package h264dp_pkg;

    // Default depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Packet status codes reported with packet_done
    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_EMPTY       = 3'd1;
    localparam logic [2:0] STATUS_UNSUPPORTED = 3'd2;
    localparam logic [2:0] STATUS_SHORT_FU    = 3'd3;
    localparam logic [2:0] STATUS_OVERRUN     = 3'd4;

    // One request from the front: what the back expands into result bytes
    typedef struct packed {
        logic       emit_prefix;   // four start code bytes first
        logic       emit_hdr;      // rebuilt FU-A NAL header after the start code
        logic       emit_byte;     // payload byte last
        logic [7:0] data;
        logic [7:0] hdr;
        logic       done;          // packet ends with this request
        logic [2:0] status;
        logic [4:0] nal;
    } cmd_t;

endpackage

// File: design/h264dp_front.sv
module h264dp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         payload_byte,
    input  logic               byte_present,
    input  logic               packet_first,
    input  logic               packet_last,
    output logic               cmd_push,
    output h264dp_pkg::cmd_t   cmd
);

    localparam logic [2:0] KIND_IDLE   = 3'd0;
    localparam logic [2:0] KIND_SINGLE = 3'd1;
    localparam logic [2:0] KIND_STAP   = 3'd2;
    localparam logic [2:0] KIND_FU     = 3'd3;
    localparam logic [2:0] KIND_DROP   = 3'd4;

    localparam logic [1:0] PH_LEN_HI = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    logic [2:0]  kind_reg,  kind_next;
    logic [1:0]  index_reg, index_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] len_reg,   len_next;
    logic [15:0] rem_reg,   rem_next;
    logic        scp_reg,   scp_next;
    logic [7:0]  ind_reg,   ind_next;
    logic [2:0]  err_reg,   err_next;
    logic [4:0]  nal_reg,   nal_next;

    // Classify the byte and update the packet state
    always_comb
    begin
        logic [4:0]  t;
        logic [15:0] len_v;
        logic [15:0] rem_dec;
        t       = payload_byte[4:0];
        len_v   = {len_reg[15:8], payload_byte};
        rem_dec = (rem_reg != 16'd0) ? rem_reg - 16'd1 : 16'd0;

        kind_next  = kind_reg;
        index_next = index_reg;
        phase_next = phase_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        scp_next   = scp_reg;
        ind_next   = ind_reg;
        err_next   = err_reg;
        nal_next   = nal_reg;

        cmd             = '0;
        cmd.data        = payload_byte;
        cmd.hdr         = ind_reg;

        if (!byte_present)
        begin
            // A lone end marker on a new packet reports an empty packet
            if (packet_last && packet_first)
            begin
                kind_next = KIND_IDLE;
            end
        end
        else if (packet_first || kind_reg == KIND_IDLE)
        begin
            // Start a new packet from its NAL or indicator byte
            kind_next  = KIND_IDLE;
            index_next = 2'd0;
            phase_next = PH_LEN_HI;
            len_next   = 16'd0;
            rem_next   = 16'd0;
            scp_next   = 1'b0;
            ind_next   = 8'd0;
            err_next   = 3'd0;
            if (t <= 5'd23)
            begin
                kind_next       = KIND_SINGLE;
                nal_next        = t;
                cmd.emit_prefix = 1'b1;
                cmd.emit_byte   = 1'b1;
            end
            else if (t == 5'd24)
            begin
                kind_next = KIND_STAP;
            end
            else if (t == 5'd28)
            begin
                kind_next  = KIND_FU;
                index_next = 2'd1;
                ind_next   = payload_byte & 8'he0;
            end
            else
            begin
                kind_next = KIND_DROP;
                err_next  = h264dp_pkg::STATUS_UNSUPPORTED;
            end
        end
        else
        begin
            unique case (kind_reg)
                KIND_SINGLE:
                begin
                    cmd.emit_byte = 1'b1;
                end
                KIND_STAP:
                begin
                    unique case (phase_reg)
                        PH_LEN_HI:
                        begin
                            len_next   = {payload_byte, 8'h00};
                            phase_next = PH_LEN_LO;
                        end
                        PH_LEN_LO:
                        begin
                            len_next   = len_v;
                            rem_next   = len_v;
                            phase_next = (len_v != 16'd0) ? PH_DATA : PH_LEN_HI;
                        end
                        default:
                        begin
                            if (rem_reg == len_reg)
                            begin
                                nal_next        = t;
                                cmd.emit_prefix = 1'b1;
                            end
                            cmd.emit_byte = 1'b1;
                            rem_next      = rem_dec;
                            if (rem_dec == 16'd0)
                            begin
                                phase_next = PH_LEN_HI;
                            end
                        end
                    endcase
                end
                KIND_FU:
                begin
                    if (index_reg < 2'd2)
                    begin
                        nal_next   = t;
                        ind_next   = {ind_reg[7:5], t};
                        scp_next   = payload_byte[7];
                        index_next = 2'd2;
                    end
                    else
                    begin
                        if (scp_reg)
                        begin
                            cmd.emit_prefix = 1'b1;
                            cmd.emit_hdr    = 1'b1;
                            scp_next        = 1'b0;
                        end
                        cmd.emit_byte = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Close the packet and report its status
        if (packet_last)
        begin
            cmd.done = 1'b1;
            unique case (kind_next)
                KIND_SINGLE: cmd.status = h264dp_pkg::STATUS_OK;
                KIND_STAP:
                begin
                    if (phase_next == PH_DATA && rem_next != 16'd0 && rem_next < len_next)
                        cmd.status = h264dp_pkg::STATUS_OVERRUN;
                    else
                        cmd.status = h264dp_pkg::STATUS_OK;
                end
                KIND_FU:
                begin
                    cmd.status = (index_next < 2'd2) ? h264dp_pkg::STATUS_SHORT_FU
                                                     : h264dp_pkg::STATUS_OK;
                end
                KIND_DROP:   cmd.status = err_next;
                default:     cmd.status = h264dp_pkg::STATUS_EMPTY;
            endcase
            kind_next  = KIND_IDLE;
            index_next = 2'd0;
            phase_next = PH_LEN_HI;
            len_next   = 16'd0;
            rem_next   = 16'd0;
            scp_next   = 1'b0;
            ind_next   = 8'd0;
            err_next   = 3'd0;
        end

        cmd.nal  = nal_next;
        cmd_push = accept && (cmd.emit_byte || packet_last);
    end

    // Advance the packet state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_IDLE;
            index_reg <= 2'd0;
            phase_reg <= PH_LEN_HI;
            len_reg   <= 16'd0;
            rem_reg   <= 16'd0;
            scp_reg   <= 1'b0;
            ind_reg   <= 8'd0;
            err_reg   <= 3'd0;
            nal_reg   <= 5'd0;
        end
        else if (accept)
        begin
            kind_reg  <= kind_next;
            index_reg <= index_next;
            phase_reg <= phase_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            scp_reg   <= scp_next;
            ind_reg   <= ind_next;
            err_reg   <= err_next;
            nal_reg   <= nal_next;
        end
    end

endmodule

// File: design/h264dp_queue.sv
module h264dp_queue
#(
    parameter int DEPTH = h264dp_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  h264dp_pkg::cmd_t  push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output h264dp_pkg::cmd_t  head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    h264dp_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/h264dp_back.sv
module h264dp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  h264dp_pkg::cmd_t  head_cmd,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        stream_byte,
    output logic              stream_valid,
    output logic              packet_done,
    output logic [2:0]        packet_status,
    output logic [4:0]        last_nal_type
);

    logic [2:0] step_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       svalid_reg;
    logic       done_reg;
    logic [2:0] status_reg;
    logic [4:0] nal_reg;

    logic       advance;
    logic       load;
    logic [2:0] last_step;
    logic       is_last;
    logic [7:0] item_byte;
    logic       item_valid;

    assign advance = !valid_reg || !out_stall;
    assign load    = advance && !q_empty;

    // Index of the final result of the head request
    always_comb
    begin
        logic [2:0] n;
        n = (head_cmd.emit_prefix ? 3'd4 : 3'd0)
            + {2'b00, head_cmd.emit_hdr} + {2'b00, head_cmd.emit_byte};
        last_step = (n == 3'd0) ? 3'd0 : n - 3'd1;
    end

    assign is_last = (step_reg == last_step);
    assign q_pop   = load && is_last;

    // Select the byte for the current step
    always_comb
    begin
        item_valid = 1'b1;
        if (head_cmd.emit_prefix && step_reg < 3'd3)
        begin
            item_byte = 8'h00;
        end
        else if (head_cmd.emit_prefix && step_reg == 3'd3)
        begin
            item_byte = 8'h01;
        end
        else if (is_last)
        begin
            item_byte  = head_cmd.emit_byte ? head_cmd.data : 8'h00;
            item_valid = head_cmd.emit_byte;
        end
        else
        begin
            item_byte = head_cmd.hdr;
        end
    end

    // Hold the result until taken, step through the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= !q_empty;
            if (load)
            begin
                step_reg <= is_last ? 3'd0 : step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= item_byte;
            svalid_reg <= item_valid;
            done_reg   <= is_last && head_cmd.done;
            status_reg <= (is_last && head_cmd.done) ? head_cmd.status
                                                     : h264dp_pkg::STATUS_OK;
            nal_reg    <= head_cmd.nal;
        end
    end

    assign out_valid     = valid_reg;
    assign stream_byte   = byte_reg;
    assign stream_valid  = svalid_reg;
    assign packet_done   = done_reg;
    assign packet_status = status_reg;
    assign last_nal_type = nal_reg;

endmodule

// File: design/h264_rtp_depacketizer.sv
// H.264 RTP payload to Annex B byte stream converter.
// Input channel (in_valid / in_stall): one request per RTP payload byte with
// payload_byte, byte_present, packet_first and packet_last. A request with
// byte_present low and packet_last high closes the packet in progress.
// Output channel (out_valid / out_stall): at most one Annex B byte per request, with
// packet_done and packet_status on the last one of each packet; a status
// other than zero tells downstream to discard the bytes of that packet.
// An accepted input is written into the request queue and then into the output register.
// Throughput: plain payload bytes pass at one per cycle while out_stall is low. A byte
// that opens a NAL unit expands to five results (six for an FU-A start), and the back
// end sends one result a cycle while out_stall is low, so once the request queue
// (QUEUE_DEPTH entries) fills, such a byte holds the input until its results are sent.
// When out_stall is high the output register holds its request, the queue
// fills, and in_stall rises while the queue is full.
// Reset clears the packet state, the queue pointers and the output valid flag; no
// output is valid until a new input is accepted.
module h264_rtp_depacketizer
#(
    parameter int QUEUE_DEPTH = h264dp_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  payload_byte,
    input  logic        byte_present,
    input  logic        packet_first,
    input  logic        packet_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  stream_byte,
    output logic        stream_valid,
    output logic        packet_done,
    output logic [2:0]  packet_status,
    output logic [4:0]  last_nal_type
);

    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic             cmd_push;
    h264dp_pkg::cmd_t cmd;
    h264dp_pkg::cmd_t head_cmd;
    logic             accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    h264dp_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .payload_byte (payload_byte),
        .byte_present (byte_present),
        .packet_first (packet_first),
        .packet_last  (packet_last),
        .cmd_push     (cmd_push),
        .cmd          (cmd)
    );

    h264dp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    h264dp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .head_cmd      (head_cmd),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .stream_byte   (stream_byte),
        .stream_valid  (stream_valid),
        .packet_done   (packet_done),
        .packet_status (packet_status),
        .last_nal_type (last_nal_type)
    );

endmodule

// File: tb/tb_h264_rtp_depacketizer.sv
module tb_h264_rtp_depacketizer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 43;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
    localparam logic [4:0] NAL_STAP_A     = 5'd24;
    localparam logic [4:0] NAL_FU_A       = 5'd28;

    localparam logic [2:0] KIND_IDLE   = 3'd0;
    localparam logic [2:0] KIND_SINGLE = 3'd1;
    localparam logic [2:0] KIND_STAP   = 3'd2;
    localparam logic [2:0] KIND_FU     = 3'd3;
    localparam logic [2:0] KIND_DROP   = 3'd4;

    localparam logic [1:0] AGG_LEN_HI = 2'd0;
    localparam logic [1:0] AGG_LEN_LO = 2'd1;
    localparam logic [1:0] AGG_DATA   = 2'd2;

    // One input request: a payload byte and its framing flags
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       first;
        logic       last;
    } byte_req_t;

    // One expected Annex B output request
    typedef struct packed {
        logic [7:0] sbyte;
        logic       svalid;
        logic       done;
        logic [2:0] status;
        logic [4:0] nal;
    } stream_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  payload_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        packet_first = 1'b0;
    logic        packet_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  stream_byte;
    logic        stream_valid;
    logic        packet_done;
    logic [2:0]  packet_status;
    logic [4:0]  last_nal_type;

    h264_rtp_depacketizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .payload_byte  (payload_byte),
        .byte_present  (byte_present),
        .packet_first  (packet_first),
        .packet_last   (packet_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .stream_byte   (stream_byte),
        .stream_valid  (stream_valid),
        .packet_done   (packet_done),
        .packet_status (packet_status),
        .last_nal_type (last_nal_type)
    );

    byte_req_t   byte_q[$];
    stream_rec_t annexb_expect[$];
    stream_rec_t step_q[$];
    logic [7:0]  pkt_bytes[$];
    byte_req_t   drive_req;

    int          send_idle = 0;
    int          recv_idle = 0;
    int          phase_items = 0;
    int          errors = 0;
    int          cycles = 0;
    logic        in_taken = 1'b0;

    // Depacketizer state mirror
    logic [2:0]  kind;
    logic [1:0]  agg;
    logic [1:0]  fu_index;
    logic [15:0] unit_len;
    logic [15:0] unit_rem;
    logic        sc_pending;
    logic [7:0]  fu_hdr;
    logic [2:0]  err_code;
    logic [4:0]  nal_held;

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Annex B predictor
    // ---------------------------------------------------------------
    task automatic clear_packet();
        kind       = KIND_IDLE;
        agg        = AGG_LEN_HI;
        fu_index   = 2'd0;
        unit_len   = 16'd0;
        unit_rem   = 16'd0;
        sc_pending = 1'b0;
        fu_hdr     = 8'h00;
        err_code   = h264dp_pkg::STATUS_OK;
    endtask

    task automatic push_byte(input logic [7:0] b);
        stream_rec_t rec;
        if (step_q.size() >= 6)
            return;
        rec.sbyte  = b;
        rec.svalid = 1'b1;
        rec.done   = 1'b0;
        rec.status = h264dp_pkg::STATUS_OK;
        rec.nal    = 5'd0;
        step_q.push_back(rec);
    endtask

    task automatic push_start_code();
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
    endtask

    function automatic logic [2:0] end_status();
        unique case (kind)
            KIND_SINGLE: return h264dp_pkg::STATUS_OK;
            KIND_STAP:
                if (agg == AGG_DATA && unit_rem != 16'd0 && unit_rem < unit_len)
                    return h264dp_pkg::STATUS_OVERRUN;
                else
                    return h264dp_pkg::STATUS_OK;
            KIND_FU:     return (fu_index < 2'd2) ? h264dp_pkg::STATUS_SHORT_FU
                                                  : h264dp_pkg::STATUS_OK;
            KIND_DROP:   return err_code;
            default:     return h264dp_pkg::STATUS_EMPTY;
        endcase
    endfunction

    task automatic predict_annexb(input logic [7:0] b, input logic pres,
                                  input logic fst, input logic lst);
        logic [4:0]  t;
        logic [2:0]  st;
        stream_rec_t rec;
        step_q.delete();
        t = b[4:0];
        if (!pres)
        begin
            if (!lst)
                return;
            if (fst)
                kind = KIND_IDLE;
        end
        else if (fst || kind == KIND_IDLE)
        begin
            // open a new packet from its first byte
            clear_packet();
            if (t <= NAL_SINGLE_MAX)
            begin
                kind     = KIND_SINGLE;
                nal_held = t;
                push_start_code();
                push_byte(b);
            end
            else if (t == NAL_STAP_A)
            begin
                kind = KIND_STAP;
            end
            else if (t == NAL_FU_A)
            begin
                kind     = KIND_FU;
                fu_index = 2'd1;
                fu_hdr   = {b[7:5], 5'd0};
            end
            else
            begin
                kind     = KIND_DROP;
                err_code = h264dp_pkg::STATUS_UNSUPPORTED;
            end
        end
        else
        begin
            unique case (kind)
                KIND_SINGLE: push_byte(b);
                KIND_STAP:
                    if (agg == AGG_LEN_HI)
                    begin
                        unit_len = {b, 8'h00};
                        agg      = AGG_LEN_LO;
                    end
                    else if (agg == AGG_LEN_LO)
                    begin
                        unit_len = unit_len | {8'h00, b};
                        unit_rem = unit_len;
                        agg      = (unit_len != 16'd0) ? AGG_DATA : AGG_LEN_HI;
                    end
                    else
                    begin
                        if (unit_rem == unit_len)
                        begin
                            nal_held = t;
                            push_start_code();
                        end
                        push_byte(b);
                        if (unit_rem != 16'd0)
                            unit_rem = unit_rem - 16'd1;
                        if (unit_rem == 16'd0)
                            agg = AGG_LEN_HI;
                    end
                KIND_FU:
                    if (fu_index < 2'd2)
                    begin
                        nal_held   = t;
                        fu_hdr     = {fu_hdr[7:5], t};
                        sc_pending = b[7];
                        fu_index   = 2'd2;
                    end
                    else
                    begin
                        if (sc_pending)
                        begin
                            push_start_code();
                            push_byte(fu_hdr);
                            sc_pending = 1'b0;
                        end
                        push_byte(b);
                    end
                default: ;
            endcase
        end

        // mark the end of the packet on its last result
        if (lst)
        begin
            st = end_status();
            if (step_q.size() == 0)
            begin
                rec = '0;
                step_q.push_back(rec);
            end
            rec = step_q.pop_back();
            rec.done   = 1'b1;
            rec.status = st;
            step_q.push_back(rec);
            clear_packet();
        end

        foreach (step_q[i])
        begin
            rec = step_q[i];
            rec.nal = nal_held;
            annexb_expect.push_back(rec);
        end
    endtask

    // ---------------------------------------------------------------
    // Output checking
    // ---------------------------------------------------------------
    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch: expected %0h, actual %0h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_stream();
        stream_rec_t want;
        if (annexb_expect.size() == 0)
        begin
            $display("%0t ns: unexpected output: expected none, actual byte %0h done %0b",
                     $time, stream_byte, packet_done);
            errors++;
        end
        else
        begin
            want = annexb_expect.pop_front();
            report_field("stream_byte", want.sbyte, stream_byte);
            report_field("stream_valid", {7'd0, want.svalid}, {7'd0, stream_valid});
            report_field("packet_done", {7'd0, want.done}, {7'd0, packet_done});
            report_field("packet_status", {5'd0, want.status}, {5'd0, packet_status});
            report_field("last_nal_type", {3'd0, want.nal}, {3'd0, last_nal_type});
        end
    endtask

    // Monitor: check accepted outputs, predict from accepted inputs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_stream();
            if (in_valid && !in_stall)
                predict_annexb(payload_byte, byte_present, packet_first, packet_last);
        end
        in_taken <= rst_n && in_valid && !in_stall;
    end

    // Driver: hold a request until taken, idle and stall at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    drive_req = byte_q.pop_front();
                    in_valid     <= 1'b1;
                    payload_byte <= drive_req.data;
                    byte_present <= drive_req.present;
                    packet_first <= drive_req.first;
                    packet_last  <= drive_req.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_h264_rtp_depacketizer failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic add_item(input logic [7:0] b, input bit pres, input bit fst,
                            input bit lst);
        byte_req_t r;
        r.data    = b;
        r.present = pres;
        r.first   = fst;
        r.last    = lst;
        byte_q.push_back(r);
        if (pres || lst)
            phase_items++;
    endtask

    // Queue the collected packet bytes with framing and some noise
    task automatic send_packet();
        int  r;
        int  end_mode;
        bit  fst;
        r = $urandom_range(99);
        end_mode = (r < 80) ? 0 : (r < 92) ? 1 : 2;
        foreach (pkt_bytes[i])
        begin
            if ($urandom_range(19) == 0)
                add_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0);
            fst = (i == 0) && ($urandom_range(9) != 0);
            add_item(pkt_bytes[i], 1'b1, fst,
                     (i == pkt_bytes.size() - 1) && (end_mode == 0));
        end
        if (end_mode == 1)
            add_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
    endtask

    task automatic gen_packet();
        int         sel;
        int         n;
        int         units;
        int         t;
        logic [7:0] upper;
        logic [7:0] hi;
        logic [7:0] lo;
        bit         stop;
        pkt_bytes.delete();
        upper = 8'($urandom_range(255)) & 8'he0;
        sel = $urandom_range(99);
        if (sel < 6)
        begin
            // raw noise request
            add_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
            return;
        end
        if (sel < 12)
        begin
            add_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b1);
            return;
        end
        if (sel < 36)
        begin
            pkt_bytes.push_back(upper | 8'($urandom_range(23)));
            n = $urandom_range(5);
            repeat (n) pkt_bytes.push_back(8'($urandom_range(255)));
        end
        else if (sel < 66)
        begin
            // aggregation packet with a few short units
            pkt_bytes.push_back(upper | {3'd0, NAL_STAP_A});
            units = $urandom_range(1, 3);
            stop = 1'b0;
            repeat (units)
            begin
                if (!stop)
                begin
                    hi = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'h00;
                    lo = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(4));
                    pkt_bytes.push_back(hi);
                    pkt_bytes.push_back(lo);
                    if (hi == 8'h00 && lo <= 8'd4)
                    begin
                        repeat (lo) pkt_bytes.push_back(8'($urandom_range(255)));
                    end
                    else
                    begin
                        n = $urandom_range(3);
                        repeat (n) pkt_bytes.push_back(8'($urandom_range(255)));
                        stop = 1'b1;
                    end
                end
            end
            if ($urandom_range(99) < 15 && pkt_bytes.size() > 2)
            begin
                n = $urandom_range(1, 2);
                repeat (n) void'(pkt_bytes.pop_back());
            end
        end
        else if (sel < 90)
        begin
            pkt_bytes.push_back(upper | {3'd0, NAL_FU_A});
            if ($urandom_range(9) != 0)
            begin
                pkt_bytes.push_back(8'($urandom_range(255)));
                n = $urandom_range(5);
                repeat (n) pkt_bytes.push_back(8'($urandom_range(255)));
            end
        end
        else
        begin
            // unsupported aggregation, fragmentation and reserved types
            t = $urandom_range(25, 30);
            if (t >= NAL_FU_A)
                t++;
            pkt_bytes.push_back(upper | t[7:0]);
            n = $urandom_range(3);
            repeat (n) pkt_bytes.push_back(8'($urandom_range(255)));
        end
        send_packet();
    endtask

    task automatic directed_items();
        // empty packet while idle
        add_item(8'h00, 1'b0, 1'b0, 1'b1);
        // single NAL units at the field extremes
        add_item(8'h00, 1'b1, 1'b1, 1'b0);
        add_item(8'hff, 1'b1, 1'b0, 1'b1);
        add_item(8'hf7, 1'b1, 1'b1, 1'b1);
        // aggregation with a zero-length unit
        add_item(8'h18, 1'b1, 1'b1, 1'b0);
        add_item(8'h00, 1'b1, 1'b0, 1'b0);
        add_item(8'h02, 1'b1, 1'b0, 1'b0);
        add_item(8'h65, 1'b1, 1'b0, 1'b0);
        add_item(8'haa, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0, 1'b0);
        add_item(8'h01, 1'b1, 1'b0, 1'b0);
        add_item(8'h41, 1'b1, 1'b0, 1'b1);
        // lone aggregation header
        add_item(8'h78, 1'b1, 1'b1, 1'b1);
        // fragment start with rebuilt header
        add_item(8'h7c, 1'b1, 1'b1, 1'b0);
        add_item(8'h85, 1'b1, 1'b0, 1'b0);
        add_item(8'h11, 1'b1, 1'b0, 1'b1);
        // fragment indicator alone
        add_item(8'h9c, 1'b1, 1'b1, 1'b1);
        // unsupported type swallowed
        add_item(8'h39, 1'b1, 1'b1, 1'b0);
        add_item(8'hab, 1'b1, 1'b0, 1'b1);
        // aggregation ends inside unit data
        add_item(8'h18, 1'b1, 1'b1, 1'b0);
        add_item(8'h00, 1'b1, 1'b0, 1'b0);
        add_item(8'h03, 1'b1, 1'b0, 1'b0);
        add_item(8'h67, 1'b1, 1'b0, 1'b1);
        // restart mid-packet, ignored gap, close with no byte
        add_item(8'h61, 1'b1, 1'b1, 1'b0);
        add_item(8'h55, 1'b0, 1'b0, 1'b0);
        add_item(8'h65, 1'b1, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0, 1'b1);
        // no byte with first and last
        add_item(8'h3c, 1'b0, 1'b1, 1'b1);
    endtask

    task automatic drain();
        while (byte_q.size() != 0 || in_valid || annexb_expect.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int s_idle, input int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        phase_items = 0;
        while (phase_items < PHASE_ITEMS)
            gen_packet();
        drain();
    endtask

    initial
    begin
        clear_packet();
        nal_held = 5'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle = 25;
        recv_idle = 56;
        directed_items();
        drain();
        run_phase(25, 56);
        run_phase(56, 25);
        run_phase(0, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (annexb_expect.size() != 0)
        begin
            $display("%0t ns: missing output: expected %0d more, actual 0",
                     $time, annexb_expect.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_h264_rtp_depacketizer passed");
        else
            $display("tb_h264_rtp_depacketizer failed");
        $finish;
    end

endmodule
